/* sv/knn_pkg.sv */
// knn_pkg: shared constants and control types of the k-nearest-neighbor selector
// depends on nothing; used by the output interface, the distance pipe, the cells and the top level
package knn_pkg;

    localparam int DIST_BITS = 50;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    localparam int CFG_BITS = 4;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd4;

    // flags that travel with one item through the distance pipe
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic insert;
    } t_pipe_flags;

    // what the cell row does in one cycle
    typedef struct packed {
        logic insert;
        logic clear;
        logic rotate;
    } t_cell_ctrl;

endpackage

/* sv/knn_in_if.sv */
// knn_in_if: input channel of the selector, one query point and one candidate per item
// depends on nothing
interface knn_in_if #(
    parameter int INDEX_BITS = 16,
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic [INDEX_BITS-1:0]        query_index;
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;
    logic [INDEX_BITS-1:0]        cand_index;
    logic signed [COORD_BITS-1:0] cand_x;
    logic signed [COORD_BITS-1:0] cand_y;
    logic                         first_item;
    logic                         last_item;

    modport source (
        output valid, query_index, query_x, query_y, cand_index, cand_x, cand_y,
               first_item, last_item,
        input  ready
    );
    modport sink (
        input  valid, query_index, query_x, query_y, cand_index, cand_x, cand_y,
               first_item, last_item,
        output ready
    );
endinterface

/* sv/knn_out_if.sv */
// knn_out_if: output channel of the selector, one ranked neighbor per item
// depends on knn_pkg for the distance width
interface knn_out_if #(
    parameter int INDEX_BITS = 16
);
    logic                           valid;
    logic                           ready;
    logic [INDEX_BITS-1:0]          neighbor_index;
    logic [knn_pkg::DIST_BITS-1:0]  neighbor_dist_sq;
    logic                           neighbor_valid;
    logic                           final_entry;

    modport source (
        output valid, neighbor_index, neighbor_dist_sq, neighbor_valid, final_entry,
        input  ready
    );
    modport sink (
        input  valid, neighbor_index, neighbor_dist_sq, neighbor_valid, final_entry,
        output ready
    );
endinterface

/* sv/knn_dist.sv */
// knn_dist: three-stage squared-distance pipe (difference, square, add and saturate)
// depends on knn_pkg
module knn_dist #(
    parameter int INDEX_BITS = 16,
    parameter int COORD_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic [INDEX_BITS-1:0]         i_query_index,
    input  logic signed [COORD_BITS-1:0]  i_query_x,
    input  logic signed [COORD_BITS-1:0]  i_query_y,
    input  logic [INDEX_BITS-1:0]         i_cand_index,
    input  logic signed [COORD_BITS-1:0]  i_cand_x,
    input  logic signed [COORD_BITS-1:0]  i_cand_y,
    input  logic                          i_first,
    input  logic                          i_last,
    output knn_pkg::t_pipe_flags          o_flags,
    output logic [INDEX_BITS-1:0]         o_cand_index,
    output logic [knn_pkg::DIST_BITS-1:0] o_dist,
    output logic                          o_last_pending
);
    localparam int DW   = COORD_BITS + 1;
    localparam int SQW  = 2 * DW;
    localparam int SUMW = SQW + 1;
    localparam int EXTW = (SUMW > knn_pkg::DIST_BITS) ? SUMW : knn_pkg::DIST_BITS;

    knn_pkg::t_pipe_flags r_f1, r_f2, r_f3;
    knn_pkg::t_pipe_flags n_f1;
    logic [INDEX_BITS-1:0] r_ci1, r_ci2, r_ci3;

    logic signed [DW-1:0] n_dx, n_dy, r_dx, r_dy;
    logic [DW-1:0]        ax, ay;
    logic [SQW-1:0]       n_sqx, n_sqy, r_sqx, r_sqy;
    logic [SUMW-1:0]      sum;
    logic [EXTW-1:0]      sum_ext;
    logic [knn_pkg::DIST_BITS-1:0] n_dist, r_dist;

    // stage 1: coordinate differences
    assign n_dx = {i_cand_x[COORD_BITS-1], i_cand_x} - {i_query_x[COORD_BITS-1], i_query_x};
    assign n_dy = {i_cand_y[COORD_BITS-1], i_cand_y} - {i_query_y[COORD_BITS-1], i_query_y};

    always_comb begin
        n_f1.valid  = i_take;
        n_f1.first  = i_first;
        n_f1.last   = i_last;
        n_f1.insert = (i_query_index != i_cand_index);
    end

    // stage 2: magnitudes squared
    assign ax    = r_dx[DW-1] ? DW'(-r_dx) : DW'(r_dx);
    assign ay    = r_dy[DW-1] ? DW'(-r_dy) : DW'(r_dy);
    assign n_sqx = SQW'(ax) * SQW'(ax);
    assign n_sqy = SQW'(ay) * SQW'(ay);

    // stage 3: sum, saturated to the reported width
    assign sum     = SUMW'(r_sqx) + SUMW'(r_sqy);
    assign sum_ext = EXTW'(sum);
    assign n_dist  = (sum_ext > EXTW'(knn_pkg::DIST_MAX)) ? knn_pkg::DIST_MAX
                                                           : sum_ext[knn_pkg::DIST_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1 <= '0;
            r_f2 <= '0;
            r_f3 <= '0;
        end else begin
            r_f1 <= n_f1;
            r_f2 <= r_f1;
            r_f3 <= r_f2;
        end
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_ci1  <= i_cand_index;
        r_sqx  <= n_sqx;
        r_sqy  <= n_sqy;
        r_ci2  <= r_ci1;
        r_dist <= n_dist;
        r_ci3  <= r_ci2;
    end

    assign o_flags        = r_f3;
    assign o_cand_index   = r_ci3;
    assign o_dist         = r_dist;
    assign o_last_pending = (r_f1.valid && r_f1.last) || (r_f2.valid && r_f2.last)
                          || (r_f3.valid && r_f3.last);

endmodule

/* sv/knn_cell.sv */
// knn_cell: one rank slot of the sorted list; compares, shifts from its left neighbor,
// or rotates during read-out; depends on knn_pkg
module knn_cell #(
    parameter int INDEX_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  knn_pkg::t_cell_ctrl           i_ctrl,
    input  logic                          i_en,
    input  logic [INDEX_BITS-1:0]         i_cand_index,
    input  logic [knn_pkg::DIST_BITS-1:0] i_cand_dist,
    input  logic                          i_prev_valid,
    input  logic [INDEX_BITS-1:0]         i_prev_index,
    input  logic [knn_pkg::DIST_BITS-1:0] i_prev_dist,
    input  logic                          i_prev_found,
    input  logic                          i_rot_valid,
    input  logic [INDEX_BITS-1:0]         i_rot_index,
    input  logic [knn_pkg::DIST_BITS-1:0] i_rot_dist,
    output logic                          o_valid,
    output logic [INDEX_BITS-1:0]         o_index,
    output logic [knn_pkg::DIST_BITS-1:0] o_dist,
    output logic                          o_found
);
    logic                          r_valid, n_valid;
    logic [INDEX_BITS-1:0]         r_index, n_index;
    logic [knn_pkg::DIST_BITS-1:0] r_dist, n_dist;
    logic                          old_valid;

    // a first item empties the list before the candidate is placed
    assign old_valid = r_valid && !i_ctrl.clear;
    // insertion point: first slot that is empty or farther than the candidate
    assign o_found   = i_prev_found || !(old_valid && (r_dist <= i_cand_dist));

    always_comb begin
        n_valid = old_valid;
        n_index = r_index;
        n_dist  = r_dist;
        if (i_ctrl.rotate && i_en) begin
            n_valid = i_rot_valid;
            n_index = i_rot_index;
            n_dist  = i_rot_dist;
        end else if (i_ctrl.insert && i_en && o_found) begin
            if (i_prev_found) begin
                n_valid = i_prev_valid && !i_ctrl.clear;
                n_index = i_prev_index;
                n_dist  = i_prev_dist;
            end else begin
                n_valid = 1'b1;
                n_index = i_cand_index;
                n_dist  = i_cand_dist;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_index <= n_index;
        r_dist  <= n_dist;
    end

    assign o_valid = r_valid;
    assign o_index = r_index;
    assign o_dist  = r_dist;

endmodule

/* sv/k_nearest_neighbor_select.sv */
// k_nearest_neighbor_select: keeps the k nearest candidates to a query point, sorted
// a candidate passes the distance pipe registers before the cell row stores it; a last item
// leaving the pipe starts the read-out, and the output register presents the first ranked
// item, then one per cycle while the sink takes them; input takes one item per cycle, set by
// the distance pipe and the cell row, while no last item is in flight or being read out
// reset: synchronous, empties the list through the valid bits, count back to 4; no sweep
module k_nearest_neighbor_select #(
    parameter int MAX_NEIGHBORS = 8,
    parameter int INDEX_BITS    = 16,
    parameter int COORD_BITS    = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    knn_in_if.sink                        i_in,
    knn_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [knn_pkg::CFG_BITS-1:0]  i_cfg_data
);
    localparam int KW = $clog2(MAX_NEIGHBORS + 1);

    // neighbor_count register and its clamped value
    logic [knn_pkg::CFG_BITS-1:0] r_cfg_count;
    logic [KW-1:0]                k_eff;

    always_comb begin
        if (r_cfg_count == '0) begin
            k_eff = KW'(1);
        end else if (32'(r_cfg_count) > 32'(MAX_NEIGHBORS)) begin
            k_eff = KW'(MAX_NEIGHBORS);
        end else begin
            k_eff = KW'(r_cfg_count);
        end
    end

    // distance pipe
    knn_pkg::t_pipe_flags          d_flags;
    logic [INDEX_BITS-1:0]         d_cand_index;
    logic [knn_pkg::DIST_BITS-1:0] d_dist;
    logic                          d_last_pending;
    logic                          in_take;

    // read-out state
    logic          r_emitting;
    logic [KW-1:0] r_emit_cnt;
    logic          emit_final;

    // output register
    logic                          r_out_valid;
    logic [INDEX_BITS-1:0]         r_out_index;
    logic [knn_pkg::DIST_BITS-1:0] r_out_dist;
    logic                          r_out_nvalid;
    logic                          r_out_final;

    knn_pkg::t_cell_ctrl ctrl;

    // hold input while a last item is in flight or the list is being read out
    assign i_in.ready = !d_last_pending && !r_emitting;
    assign in_take    = i_in.valid && i_in.ready;

    knn_dist #(
        .INDEX_BITS (INDEX_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (in_take),
        .i_query_index  (i_in.query_index),
        .i_query_x      (i_in.query_x),
        .i_query_y      (i_in.query_y),
        .i_cand_index   (i_in.cand_index),
        .i_cand_x       (i_in.cand_x),
        .i_cand_y       (i_in.cand_y),
        .i_first        (i_in.first_item),
        .i_last         (i_in.last_item),
        .o_flags        (d_flags),
        .o_cand_index   (d_cand_index),
        .o_dist         (d_dist),
        .o_last_pending (d_last_pending)
    );

    // cell row control: a self candidate still clears, it just does not insert
    always_comb begin
        ctrl.insert = d_flags.valid && d_flags.insert;
        ctrl.clear  = d_flags.valid && d_flags.first;
        // during read-out, rotate the first k cells by one whenever the output register can take an item
        ctrl.rotate = r_emitting && (!r_out_valid || o_out.ready);
    end

    logic                          c_valid [MAX_NEIGHBORS];
    logic [INDEX_BITS-1:0]         c_index [MAX_NEIGHBORS];
    logic [knn_pkg::DIST_BITS-1:0] c_dist  [MAX_NEIGHBORS];
    logic                          c_found [MAX_NEIGHBORS];

    for (genvar gi = 0; gi < MAX_NEIGHBORS; gi++) begin : g_cell
        logic                          en;
        logic                          tail;
        logic                          p_valid;
        logic [INDEX_BITS-1:0]         p_index;
        logic [knn_pkg::DIST_BITS-1:0] p_dist;
        logic                          p_found;
        logic                          rt_valid;
        logic [INDEX_BITS-1:0]         rt_index;
        logic [knn_pkg::DIST_BITS-1:0] rt_dist;

        // only the first k slots take part in insertion and read-out
        assign en   = (32'(gi) < 32'(k_eff));
        assign tail = (32'(gi) == 32'(k_eff) - 32'd1);

        if (gi == 0) begin : g_head
            assign p_valid = 1'b0;
            assign p_index = '0;
            assign p_dist  = '0;
            assign p_found = 1'b0;
        end else begin : g_body
            assign p_valid = c_valid[gi-1];
            assign p_index = c_index[gi-1];
            assign p_dist  = c_dist[gi-1];
            assign p_found = c_found[gi-1];
        end

        // the slot at rank k-1 wraps around to the head, so k steps restore the list
        if (gi == MAX_NEIGHBORS - 1) begin : g_wrap
            assign rt_valid = c_valid[0];
            assign rt_index = c_index[0];
            assign rt_dist  = c_dist[0];
        end else begin : g_next
            assign rt_valid = tail ? c_valid[0] : c_valid[gi+1];
            assign rt_index = tail ? c_index[0] : c_index[gi+1];
            assign rt_dist  = tail ? c_dist[0]  : c_dist[gi+1];
        end

        knn_cell #(
            .INDEX_BITS (INDEX_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_en         (en),
            .i_cand_index (d_cand_index),
            .i_cand_dist  (d_dist),
            .i_prev_valid (p_valid),
            .i_prev_index (p_index),
            .i_prev_dist  (p_dist),
            .i_prev_found (p_found),
            .i_rot_valid  (rt_valid),
            .i_rot_index  (rt_index),
            .i_rot_dist   (rt_dist),
            .o_valid      (c_valid[gi]),
            .o_index      (c_index[gi]),
            .o_dist       (c_dist[gi]),
            .o_found      (c_found[gi])
        );
    end

    assign emit_final = (r_emit_cnt == k_eff - KW'(1));

    // config, read-out sequencing and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= knn_pkg::CFG_RESET;
            r_emitting  <= 1'b0;
            r_emit_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_count <= i_cfg_data;
            end
            // a last item leaving the distance pipe starts the read-out
            if (d_flags.valid && d_flags.last) begin
                r_emitting <= 1'b1;
                r_emit_cnt <= '0;
            end else if (ctrl.rotate) begin
                if (emit_final) begin
                    r_emitting <= 1'b0;
                    r_emit_cnt <= '0;
                end else begin
                    r_emit_cnt <= r_emit_cnt + KW'(1);
                end
            end
            if (ctrl.rotate) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (ctrl.rotate) begin
            // unfilled slots report zero index and distance
            r_out_index  <= c_valid[0] ? c_index[0] : '0;
            r_out_dist   <= c_valid[0] ? c_dist[0]  : '0;
            r_out_nvalid <= c_valid[0];
            r_out_final  <= emit_final;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.neighbor_index   = r_out_index;
    assign o_out.neighbor_dist_sq = r_out_dist;
    assign o_out.neighbor_valid   = r_out_nvalid;
    assign o_out.final_entry      = r_out_final;

    // read-out never overlaps an insertion
    a_no_insert_in_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctrl.insert && ctrl.rotate))
        else $error("insertion during read-out");

    // input is held for the whole read-out
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emitting |-> !i_in.ready)
        else $error("input ready during read-out");

    // the read-out counter stays below the neighbor count
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emitting |-> (r_emit_cnt < k_eff))
        else $error("read-out counter out of range");

    // the final entry ends the read-out and is presented next
    a_final_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.rotate && emit_final) |=> (!r_emitting && o_out.valid && o_out.final_entry))
        else $error("read-out did not end on final entry");

endmodule

/* sim/knn_checker.sv */
// knn_checker: watches both channels and the count writes of the selector, ranks the
// candidates itself and compares every ranked neighbor that leaves the block
// depends on knn_pkg, knn_in_if and knn_out_if
module knn_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    knn_in_if                             in_ch,
    knn_out_if                            out_ch,
    input  logic                          i_cfg_we,
    input  logic [knn_pkg::CFG_BITS-1:0]  i_cfg_data,
    output int                            o_mismatches,
    output int                            o_pending,
    output int                            o_compared
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 8;

    typedef struct {
        logic [15:0]                   index;
        logic [knn_pkg::DIST_BITS-1:0] dist_sq;
        logic                          used;
        logic                          last_rank;
    } t_rank;

    logic [15:0]                   near_index [SLOTS];
    logic [knn_pkg::DIST_BITS-1:0] near_dist  [SLOTS];
    logic                          near_used  [SLOTS];
    logic [knn_pkg::CFG_BITS-1:0]  count_reg;
    t_rank                         ranked_neighbors_q [$];

    // count 0 behaves as 1, anything past the row length as the row length
    function automatic int slots_in_use(logic [knn_pkg::CFG_BITS-1:0] count);
        if (count == 0) return 1;
        if (count > SLOTS) return SLOTS;
        return int'(count);
    endfunction

    function automatic logic [knn_pkg::DIST_BITS-1:0] squared_distance(
        logic signed [23:0] qx, logic signed [23:0] qy,
        logic signed [23:0] cx, logic signed [23:0] cy);
        longint          dx;
        longint          dy;
        longint unsigned sum;
        dx  = longint'(cx) - longint'(qx);
        dy  = longint'(cy) - longint'(qy);
        sum = longint'(dx * dx) + longint'(dy * dy);
        if (sum > longint'(knn_pkg::DIST_MAX)) return knn_pkg::DIST_MAX;
        return sum[knn_pkg::DIST_BITS-1:0];
    endfunction

    task automatic empty_list();
        for (int i = 0; i < SLOTS; i++) begin
            near_index[i] = '0;
            near_dist[i]  = knn_pkg::DIST_MAX;
            near_used[i]  = 1'b0;
        end
    endtask

    task automatic rank_candidate();
        int                            k;
        int                            pos;
        logic [knn_pkg::DIST_BITS-1:0] d;
        t_rank                         r;
        k = slots_in_use(count_reg);
        if (in_ch.first_item) empty_list();
        if (in_ch.query_index != in_ch.cand_index) begin
            d = squared_distance(in_ch.query_x, in_ch.query_y, in_ch.cand_x, in_ch.cand_y);
            pos = 0;
            // ties stay behind the earlier entries
            while (pos < k && near_used[pos] && near_dist[pos] <= d) pos++;
            if (pos < k) begin
                for (int i = k - 1; i > pos; i--) begin
                    near_index[i] = near_index[i-1];
                    near_dist[i]  = near_dist[i-1];
                    near_used[i]  = near_used[i-1];
                end
                near_index[pos] = in_ch.cand_index;
                near_dist[pos]  = d;
                near_used[pos]  = 1'b1;
            end
        end
        if (in_ch.last_item) begin
            for (int i = 0; i < k; i++) begin
                r.index     = near_used[i] ? near_index[i] : '0;
                r.dist_sq   = near_used[i] ? near_dist[i] : '0;
                r.used      = near_used[i];
                r.last_rank = (i == k - 1);
                ranked_neighbors_q = {ranked_neighbors_q, r};
            end
        end
    endtask

    task automatic compare_rank();
        t_rank r;
        if (ranked_neighbors_q.size() == 0) begin
            $error("ranked neighbor item with none outstanding: index %0d",
                   out_ch.neighbor_index);
            o_mismatches++;
        end else begin
            r = ranked_neighbors_q.pop_front();
            o_compared++;
            if (out_ch.neighbor_index !== r.index) begin
                $error("neighbor_index: expected %0d, got %0d", r.index, out_ch.neighbor_index);
                o_mismatches++;
            end
            if (out_ch.neighbor_dist_sq !== r.dist_sq) begin
                $error("neighbor_dist_sq: expected %0d, got %0d",
                       r.dist_sq, out_ch.neighbor_dist_sq);
                o_mismatches++;
            end
            if (out_ch.neighbor_valid !== r.used) begin
                $error("neighbor_valid: expected %0d, got %0d", r.used, out_ch.neighbor_valid);
                o_mismatches++;
            end
            if (out_ch.final_entry !== r.last_rank) begin
                $error("final_entry: expected %0d, got %0d", r.last_rank, out_ch.final_entry);
                o_mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            count_reg = knn_pkg::CFG_RESET;
            empty_list();
            ranked_neighbors_q.delete();
            o_mismatches = 0;
            o_compared   = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) compare_rank();
            if (i_cfg_we) count_reg = i_cfg_data;
            if (in_ch.valid && in_ch.ready) rank_candidate();
        end
        o_pending = ranked_neighbors_q.size();
    end

endmodule

/* sim/tb_k_nearest_neighbor_select.sv */
// tb_k_nearest_neighbor_select: drives point pairs and count writes into the selector
// and gives the verdict; ranking and comparison live in knn_checker
// depends on knn_pkg, knn_in_if, knn_out_if, knn_checker and k_nearest_neighbor_select
module tb_k_nearest_neighbor_select;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW               = knn_pkg::CFG_BITS;
    localparam int RANDOM_ITEMS     = 370;
    localparam int QUIET_TAIL_ITEMS = 70;
    localparam int SINK_HOLD_CYCLES = 90;
    localparam int DRAIN_CYCLES     = 16;   // covers the distance pipe with room to spare

    // one query point plus one candidate, as it goes over the input channel
    typedef struct {
        logic [15:0] qi;
        logic [23:0] qx;
        logic [23:0] qy;
        logic [15:0] ci;
        logic [23:0] cx;
        logic [23:0] cy;
        logic        first;
        logic        last;
    } t_point_pair;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [CW-1:0] i_cfg_data = knn_pkg::CFG_RESET;

    int rank_mismatches;
    int ranks_pending;
    int ranks_compared;
    int items_sent = 0;
    int lists_sent = 0;
    int counts_written = 0;
    bit quiet = 1'b0;       // no idling on either side
    bit long_hold = 1'b0;   // asks the sink process for one long stall

    knn_in_if  in_ch ();
    knn_out_if out_ch ();

    k_nearest_neighbor_select u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    knn_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (rank_mismatches),
        .o_pending    (ranks_pending),
        .o_compared   (ranks_compared)
    );

    always #5 i_clk = ~i_clk;

    // hard stop well past the slowest legal run
    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    // offer one item, sometimes after a short gap, and hold it until the block takes it
    task automatic push_item(input t_point_pair p);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.query_index <= p.qi;
        in_ch.query_x     <= p.qx;
        in_ch.query_y     <= p.qy;
        in_ch.cand_index  <= p.ci;
        in_ch.cand_x      <= p.cx;
        in_ch.cand_y      <= p.cy;
        in_ch.first_item  <= p.first;
        in_ch.last_item   <= p.last;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        if (p.last) lists_sent++;
    endtask

    task automatic send_pair(input logic [15:0] qi, input logic [23:0] qx, input logic [23:0] qy,
                             input logic [15:0] ci, input logic [23:0] cx, input logic [23:0] cy,
                             input logic first, input logic last);
        t_point_pair p;
        p = '{qi, qx, qy, ci, cx, cy, first, last};
        push_item(p);
    endtask

    // count writes only land on an idle block: input quiet, every ranked item
    // delivered, and the pipe plus the read-out rotation given time to settle
    task automatic write_count(input logic [CW-1:0] value);
        in_ch.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (ranks_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        counts_written++;
    endtask

    // a coordinate close to the center (many equal distances) or anywhere at all
    function automatic logic [23:0] near_coord(logic [23:0] center, bit wide);
        if (wide) return 24'($urandom);
        return center + 24'($urandom_range(0, 16)) - 24'd8;
    endfunction

    // one query with len candidates; now and then the clear or the read-out is left off,
    // so lists run on into the next one or are thrown away by the next clear
    task automatic send_random_list(input int len);
        logic [15:0] q_id;
        logic [23:0] qx;
        logic [23:0] qy;
        bit          wide;
        bit          no_first;
        bit          no_last;
        t_point_pair p;
        q_id     = 16'($urandom);
        wide     = ($urandom_range(0, 4) == 0);
        qx       = wide ? 24'($urandom) : 24'($urandom_range(0, 2048)) - 24'd1024;
        qy       = wide ? 24'($urandom) : 24'($urandom_range(0, 2048)) - 24'd1024;
        no_first = ($urandom_range(0, 7) == 0);
        no_last  = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++) begin
            p.qi    = q_id;
            p.qx    = qx;
            p.qy    = qy;
            // self candidates with the query's own index show up now and then
            p.ci    = ($urandom_range(0, 7) == 0) ? q_id : 16'($urandom);
            p.cx    = near_coord(qx, wide || $urandom_range(0, 15) == 0);
            p.cy    = near_coord(qy, wide || $urandom_range(0, 15) == 0);
            p.first = (i == 0) && !no_first;
            p.last  = (i == len - 1) && !no_last;
            push_item(p);
        end
    endtask

    // sink side: mostly ready, short random stalls, and one long hold on request
    initial begin
        out_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold) begin
                out_ch.ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [CW-1:0] phase_counts [10];
        int            item_goal;
        int            phase;

        phase_counts = '{4'd1, 4'd8, 4'd3, 4'd15, 4'd0, 4'd2, 4'd6, 4'd7, 4'd5, 4'd4};

        // every block input known from time zero
        in_ch.valid       <= 1'b0;
        in_ch.query_index <= '0;
        in_ch.query_x     <= '0;
        in_ch.query_y     <= '0;
        in_ch.cand_index  <= '0;
        in_ch.cand_x      <= '0;
        in_ch.cand_y      <= '0;
        in_ch.first_item  <= 1'b0;
        in_ch.last_item   <= 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part, count still at its reset value of 4 ---
        // self candidate together with the clear: list emptied, no insertion
        send_pair(16'd5, 24'd0, 24'd0, 16'd5, 24'd0, 24'd0, 1'b1, 1'b0);
        // two candidates at the same distance: the earlier one keeps its rank
        send_pair(16'd5, 24'd0, 24'd0, 16'd10, 24'd768, 24'd1024, 1'b0, 1'b0);
        send_pair(16'd5, 24'd0, 24'd0, 16'd11, -24'd768, -24'd1024, 1'b0, 1'b0);
        // zero distance goes to the front
        send_pair(16'd5, 24'd0, 24'd0, 16'd12, 24'd0, 24'd0, 1'b0, 1'b0);
        // far corner, later pushed out of the four kept slots
        send_pair(16'd5, 24'd0, 24'd0, 16'd13, 24'h7fffff, 24'h800000, 1'b0, 1'b0);
        send_pair(16'd5, 24'd0, 24'd0, 16'd14, 24'd256, 24'd0, 1'b0, 1'b0);
        // self candidate with the read-out flag still emits the list
        send_pair(16'd5, 24'd0, 24'd0, 16'd5, 24'd0, 24'd0, 1'b0, 1'b1);

        // opposite corners give the largest squared distance; two slots stay unfilled
        send_pair(16'd0, 24'h800000, 24'h800000, 16'hffff, 24'h7fffff, 24'h7fffff, 1'b1, 1'b0);
        send_pair(16'd0, 24'h800000, 24'h800000, 16'd1, 24'h800000, 24'h800000, 1'b0, 1'b1);
        // clear and read-out on one item
        send_pair(16'hffff, 24'h7fffff, 24'h800000, 16'd0, 24'h800000, 24'h7fffff, 1'b1, 1'b1);
        // a list of nothing but the query itself: every slot unfilled
        send_pair(16'h1234, 24'd100, 24'd100, 16'h1234, 24'd5, 24'd5, 1'b1, 1'b1);

        // count zero keeps a single neighbor
        write_count(4'd0);
        send_pair(16'd7, 24'd0, 24'd0, 16'd20, 24'd3, 24'd4, 1'b1, 1'b0);
        send_pair(16'd7, 24'd0, 24'd0, 16'd21, 24'd4, 24'd3, 1'b0, 1'b0);
        send_pair(16'd7, 24'd0, 24'd0, 16'd22, 24'd1, 24'd1, 1'b0, 1'b1);

        // count beyond the row keeps all eight, then shrinks to two in the middle of a list
        write_count(4'd15);
        send_random_list(6);
        write_count(4'd2);
        send_pair(16'd9, 24'd0, 24'd0, 16'd30, 24'd2, 24'd2, 1'b0, 1'b0);
        send_pair(16'd9, 24'd0, 24'd0, 16'd31, 24'd1, 24'd0, 1'b0, 1'b1);

        // --- random part, one count setting per phase ---
        item_goal = items_sent + RANDOM_ITEMS;
        phase = 0;
        while (items_sent < item_goal) begin
            write_count(phase < 10 ? phase_counts[phase] : CW'($urandom_range(0, 15)));
            if (phase == 3) begin
                // sink holds off while full lists keep coming, so the block backs up
                long_hold = 1'b1;
                repeat (3) send_random_list(8);
            end
            repeat (6) begin
                if (items_sent >= item_goal - QUIET_TAIL_ITEMS) quiet = 1'b1;
                send_random_list($urandom_range(1, 12));
            end
            phase++;
        end

        in_ch.valid <= 1'b0;
        while (ranks_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d point pairs in %0d read-out lists under %0d count writes",
                 items_sent, lists_sent, counts_written);
        $display("%0d ranked neighbors compared, %0d mismatches",
                 ranks_compared, rank_mismatches);
        if (rank_mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
